// File: src/wildcard_pattern_matcher_core_macros.svh
// ----------------------------------------------------------------------------
// wildcard pattern matcher assertion macros
// shared assertion forms, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_CORE_MACROS_SVH
`define WILDCARD_PATTERN_MATCHER_CORE_MACROS_SVH

`ifndef SYNTH
`define WPM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wpm assertion failed");
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wpm assertion failed");
`else
`define WPM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define WPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// types and constants shared by the wildcard pattern matcher
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    // per-item control broadcast along the row of cells
    typedef struct packed {
        logic       clear;
        logic       append;
        logic       text;
        logic       rearm;
        logic [7:0] ch;
    } t_wpm_ctrl;

    typedef struct packed {
        logic ovf;
        logic matched;
    } t_wpm_result;

endpackage

// File: src/wildcard_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core
// glob matcher: '?' matches one byte, '*' any run, against a stored pattern
// ----------------------------------------------------------------------------
// input channel s_axis: tuser carries the op (clear, append pattern byte,
// text byte, end of text), tdata carries the byte. pattern bytes are appended
// first, text bytes then stream in, and an end-of-text item yields one result
// item on m_axis (bit 0 matched, bit 1 pattern overflow) and re-arms the row.
// one item is taken per cycle; every op finishes in the cycle it is accepted.
// a result is registered in the output register, or in the skid stage while the receiver stalls.
// the row of MAX_PATTERN cells updates together; the star closure across
// the row is a single carry chain of MAX_PATTERN+1 bits, which sets the clock.
// a stalled receiver holds one result in the output register and one in a
// skid stage; s_axis_tready drops only while both are full.
// reset empties the pattern, clears the overflow flag, arms the row and
// drops any pending result; stored pattern bytes are not cleared.
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_core_macros.svh"

module wildcard_pattern_matcher_core #(
    parameter int MAX_PATTERN = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [wpm_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // [7:0] char_in
    input  logic [wpm_pkg::IN_USER_W-1:0]   s_axis_tuser,  // [1:0] op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [wpm_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // [0] matched, [1] overflow
);
    import wpm_pkg::*;

    localparam int N     = MAX_PATTERN;
    localparam int LEN_W = $clog2(N + 1);

    logic             in_acc;
    t_wpm_ctrl        ctrl;
    logic [LEN_W-1:0] r_len;
    logic             r_ovf;
    logic             r_raw0;
    logic [N:0]       raw;
    logic [N:0]       prop;
    logic [N:0]       cl;
    logic             full;
    logic             room;
    t_wpm_result      res;
    t_wpm_result      out_res;

    assign s_axis_tready = room;
    assign in_acc        = s_axis_tvalid && room;
    assign full          = (r_len == LEN_W'(N));

    always_comb begin
        ctrl.clear  = 1'b0;
        ctrl.append = 1'b0;
        ctrl.text   = 1'b0;
        ctrl.rearm  = 1'b0;
        ctrl.ch     = s_axis_tdata;
        if (in_acc) begin
            unique case (s_axis_tuser)
                OP_CLEAR:  ctrl.clear  = 1'b1;
                OP_APPEND: ctrl.append = 1'b1;
                OP_TEXT:   ctrl.text   = 1'b1;
                OP_END:    ctrl.rearm  = 1'b1;
                default:   ctrl.clear  = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_ovf  <= 1'b0;
            r_raw0 <= 1'b1;
        end else begin
            if (ctrl.clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end else if (ctrl.append) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + LEN_W'(1);
                end
            end
            if (ctrl.clear || ctrl.rearm) begin
                r_raw0 <= 1'b1;
            end else if (ctrl.text) begin
                r_raw0 <= 1'b0;
            end
        end
    end

    assign raw[0]  = r_raw0;
    assign prop[N] = 1'b0;

    for (genvar j = 1; j <= N; j++) begin : g_cell
        wpm_cell #(
            .IDX   (j),
            .LEN_W (LEN_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl),
            .i_len     (r_len),
            .i_cl_left (cl[j-1]),
            .i_cl_self (cl[j]),
            .o_raw     (raw[j]),
            .o_prop    (prop[j-1])
        );
    end

    wpm_closure #(
        .N (N)
    ) u_closure (
        .i_raw  (raw),
        .i_prop (prop),
        .o_cl   (cl)
    );

    assign res.matched = cl[r_len];
    assign res.ovf     = r_ovf;

    wpm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ctrl.rearm),
        .i_res   (res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 2)'(0), out_res.ovf, out_res.matched};

    `WPM_ASSERT_SAME(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LEN_W'(N))
    `WPM_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, ctrl.rearm, m_axis_tvalid)
    `WPM_ASSERT_NEXT(a_full_sets_ovf, i_clk, i_rst_n, ctrl.append && full, r_ovf && full)
    `WPM_ASSERT_NEXT(a_end_rearms, i_clk, i_rst_n, ctrl.rearm, r_raw0)

endmodule

// File: src/wpm_cell.sv
// ----------------------------------------------------------------------------
// wpm_cell
// one pattern position: holds its pattern byte and its raw prefix match bit
// ----------------------------------------------------------------------------
module wpm_cell #(
    parameter int IDX   = 1,
    parameter int LEN_W = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wpm_pkg::t_wpm_ctrl i_ctrl,
    input  logic [LEN_W-1:0]   i_len,
    input  logic               i_cl_left,
    input  logic               i_cl_self,
    output logic               o_raw,
    output logic               o_prop
);
    import wpm_pkg::*;

    logic [7:0] r_pat;
    logic       r_raw;
    logic       n_raw;
    logic       active;
    logic       wr;
    logic       is_star;
    logic       hit;

    assign active  = (i_len >= LEN_W'(IDX));
    assign wr      = i_ctrl.append && (i_len == LEN_W'(IDX - 1));
    assign is_star = (r_pat == STAR_BYTE);
    assign hit     = (r_pat == ANY_BYTE) || (r_pat == i_ctrl.ch);

    always_comb begin
        n_raw = r_raw;
        if (i_ctrl.clear || i_ctrl.rearm) begin
            n_raw = 1'b0;
        end else if (wr) begin
            // new position starts unreached
            n_raw = 1'b0;
        end else if (i_ctrl.text && active) begin
            n_raw = is_star ? i_cl_self : (i_cl_left && hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw <= 1'b0;
        end else begin
            r_raw <= n_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_pat <= i_ctrl.ch;
        end
    end

    assign o_raw  = r_raw;
    assign o_prop = active && is_star;

endmodule

// File: src/wpm_closure.sv
// ----------------------------------------------------------------------------
// wpm_closure
// star closure of the match row, done as one carry chain
// ----------------------------------------------------------------------------
module wpm_closure #(
    parameter int N = 64
) (
    input  logic [N:0] i_raw,
    input  logic [N:0] i_prop,
    output logic [N:0] o_cl
);
    logic [N:0] gen;
    logic [N:0] sum;
    logic [N:0] carry;

    // a star passes a reached prefix on like a carry: generate = reached star,
    // propagate = star
    assign gen   = i_prop & i_raw;
    assign sum   = i_prop + gen;
    assign carry = sum ^ i_prop ^ gen;
    assign o_cl  = i_raw | carry;

endmodule

// File: src/wpm_out_buf.sv
// ----------------------------------------------------------------------------
// wpm_out_buf
// output register with a skid stage for result items
// ----------------------------------------------------------------------------
module wpm_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  wpm_pkg::t_wpm_result i_res,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output wpm_pkg::t_wpm_result o_res
);
    import wpm_pkg::*;

    logic        r_out_valid;
    logic        r_skd_valid;
    t_wpm_result r_out;
    t_wpm_result r_skd;
    logic        pop;

    assign pop = r_out_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (pop) begin
                r_skd_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (pop) begin
                r_out <= r_skd;
            end
        end else if (i_push) begin
            if (r_out_valid && !pop) begin
                r_skd <= i_res;
            end else begin
                r_out <= i_res;
            end
        end
    end

    assign o_room  = !r_skd_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

// File: dv/wildcard_pattern_matcher_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core_tb
// drives patterns, texts and end-of-text items into the glob matcher and
// compares each verdict to a bench row-at-a-time matcher or to a typed verdict
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_core_tb;
    import wpm_pkg::*;

    localparam int PAT_DEPTH   = 64;
    localparam int ITEM_TARGET = 2000;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;
    localparam int DIR_ROWS    = 26;

    typedef enum logic {BY_MODEL, TYPED} t_chk;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        t_chk       chk;
        logic       matched;
        logic       ovf;
    } t_stim_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] char_in
    logic [1:0] s_axis_tuser = '0;   // [1:0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [0] matched, [1] overflow, [7:2] zero

    // matcher state mirrored in the bench
    logic [7:0]         pat_bytes [PAT_DEPTH];
    logic [PAT_DEPTH:0] prefix_row;
    int unsigned        pat_len;
    logic               pat_ovf;

    t_wpm_result verdict_q [$];
    t_stim_row   dir_rows [DIR_ROWS];
    logic [7:0]  gen_pat [$];
    logic [7:0]  text_q [$];

    int  errors;
    int  items_sent;
    int  verdicts_seen;
    int  matches_seen;
    int  ovf_seen;
    int  cycles;
    bit  no_idle;

    wildcard_pattern_matcher_core #(.MAX_PATTERN(PAT_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // row with every star that can match empty folded in
    function automatic logic [PAT_DEPTH:0] closed_prefixes();
        logic [PAT_DEPTH:0] c;
        int                 j;
        c = prefix_row;
        for (j = 1; j <= pat_len; j++) begin
            if (pat_bytes[j-1] == STAR_BYTE && c[j-1]) begin
                c[j] = 1'b1;
            end
        end
        return c;
    endfunction

    function automatic bit glob_step(input logic [1:0] op, input logic [7:0] ch,
                                     output t_wpm_result res);
        logic [PAT_DEPTH:0] c;
        int                 j;
        res = '0;
        case (op)
            OP_CLEAR: begin
                pat_len    = 0;
                pat_ovf    = 1'b0;
                prefix_row = 1;
            end
            OP_APPEND: begin
                if (pat_len >= PAT_DEPTH) begin
                    pat_ovf = 1'b1;
                end else begin
                    pat_bytes[pat_len] = ch;
                    pat_len++;
                    prefix_row[pat_len] = 1'b0;
                end
            end
            OP_TEXT: begin
                c = closed_prefixes();
                prefix_row[0] = 1'b0;
                for (j = 1; j <= pat_len; j++) begin
                    if (pat_bytes[j-1] == STAR_BYTE) begin
                        prefix_row[j] = c[j];
                    end else begin
                        prefix_row[j] = c[j-1] &&
                            (pat_bytes[j-1] == ANY_BYTE || pat_bytes[j-1] == ch);
                    end
                end
            end
            default: begin
                c = closed_prefixes();
                res.matched = c[pat_len];
                res.ovf     = pat_ovf;
                prefix_row  = 1;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                 what, cycles, want, got);
        errors++;
    endtask

    // one item on s_axis, with random idle cycles ahead of it unless no_idle is set
    task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                             input t_chk chk, input t_wpm_result typed_res);
        t_wpm_result res;
        while (!no_idle && $urandom_range(0, 99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= ch;
        do @(posedge i_clk); while (!s_axis_tready);
        if (glob_step(op, ch, res)) begin
            verdict_q.push_back(chk == TYPED ? typed_res : res);
        end
        items_sent++;
        no_idle = (items_sent >= 900 && items_sent < 1300);
    endtask

    function automatic logic [7:0] pick_pat_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return STAR_BYTE;
        if (r < 5) return ANY_BYTE;
        if (r < 9) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 9) < 8) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    // when new_pattern is set, load a fresh pattern; then run one to three texts against it
    task automatic run_session(input bit new_pattern);
        int          plen;
        int          r;
        int          k;
        int          n;
        int          pos;
        logic [7:0]  b;
        if (new_pattern) begin
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)), BY_MODEL, '0);
            gen_pat.delete();
            r = $urandom_range(0, 99);
            if (r < 84) plen = $urandom_range(0, 10);
            else if (r < 92) plen = $urandom_range(40, PAT_DEPTH);
            else plen = $urandom_range(PAT_DEPTH + 1, PAT_DEPTH + 8);
            for (k = 0; k < plen; k++) begin
                b = pick_pat_byte();
                send_item(OP_APPEND, b, BY_MODEL, '0);
                if (gen_pat.size() < PAT_DEPTH) gen_pat.push_back(b);
            end
        end
        repeat ($urandom_range(1, 3)) begin
            // expand the pattern into a text that matches it
            text_q.delete();
            foreach (gen_pat[k]) begin
                if (gen_pat[k] == STAR_BYTE) begin
                    n = $urandom_range(0, 3);
                    repeat (n) text_q.push_back(pick_text_byte());
                end else if (gen_pat[k] == ANY_BYTE) begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    text_q.push_back(gen_pat[k]);
                end
            end
            // then break some of them
            if ($urandom_range(0, 9) < 3) begin
                pos = $urandom_range(0, text_q.size());
                r   = $urandom_range(0, 2);
                if (r == 0 || pos == text_q.size()) text_q.insert(pos, pick_text_byte());
                else if (r == 1) text_q[pos] = pick_text_byte();
                else text_q.delete(pos);
            end
            foreach (text_q[k]) begin
                if ($urandom_range(0, 99) < 2) begin
                    b = pick_pat_byte();
                    send_item(OP_APPEND, b, BY_MODEL, '0);
                    if (gen_pat.size() < PAT_DEPTH) gen_pat.push_back(b);
                end
                send_item(OP_TEXT, text_q[k], BY_MODEL, '0);
            end
            send_item(OP_END, 8'($urandom_range(0, 255)), BY_MODEL, '0);
        end
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 8);
    end

    always @(posedge i_clk) begin
        t_wpm_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("unexpected result item", 0, 1);
            end else begin
                want = verdict_q.pop_front();
                verdicts_seen++;
                matches_seen += want.matched;
                ovf_seen     += want.ovf;
                if (m_axis_tdata[0] !== want.matched)
                    report_mismatch("matched", want.matched, m_axis_tdata[0]);
                if (m_axis_tdata[1] !== want.ovf)
                    report_mismatch("pattern_overflow", want.ovf, m_axis_tdata[1]);
                if (m_axis_tdata[7:2] !== 6'd0)
                    report_mismatch("tdata padding", 0, m_axis_tdata[7:2]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", verdict_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        int k;
        pat_len    = 0;
        pat_ovf    = 1'b0;
        prefix_row = 1;
        foreach (pat_bytes[k]) pat_bytes[k] = 8'h00;
        dir_rows = '{
            '{OP_END,    8'h00,     TYPED,    1'b1, 1'b0},  // empty pattern, empty text
            '{OP_TEXT,   8'hFF,     BY_MODEL, 1'b0, 1'b0},
            '{OP_END,    8'hFF,     TYPED,    1'b0, 1'b0},  // empty pattern, one byte
            '{OP_APPEND, STAR_BYTE, BY_MODEL, 1'b0, 1'b0},
            '{OP_END,    8'h00,     TYPED,    1'b1, 1'b0},  // lone star on empty text
            '{OP_TEXT,   STAR_BYTE, BY_MODEL, 1'b0, 1'b0},  // star against a text star
            '{OP_TEXT,   8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_END,    8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_CLEAR,  8'h55,     BY_MODEL, 1'b0, 1'b0},
            '{OP_APPEND, ANY_BYTE,  BY_MODEL, 1'b0, 1'b0},
            '{OP_APPEND, 8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_TEXT,   STAR_BYTE, BY_MODEL, 1'b0, 1'b0},
            '{OP_TEXT,   8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_END,    8'hFF,     BY_MODEL, 1'b0, 1'b0},
            '{OP_TEXT,   8'hFF,     BY_MODEL, 1'b0, 1'b0},
            '{OP_APPEND, 8'hFF,     BY_MODEL, 1'b0, 1'b0},  // grows the pattern mid-text
            '{OP_TEXT,   8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_END,    8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_CLEAR,  8'hAA,     BY_MODEL, 1'b0, 1'b0},
            '{OP_APPEND, 8'h61,     BY_MODEL, 1'b0, 1'b0},
            '{OP_TEXT,   ANY_BYTE,  BY_MODEL, 1'b0, 1'b0},  // text '?' is an ordinary byte
            '{OP_END,    8'h00,     BY_MODEL, 1'b0, 1'b0},
            '{OP_APPEND, STAR_BYTE, BY_MODEL, 1'b0, 1'b0},
            '{OP_TEXT,   8'h61,     BY_MODEL, 1'b0, 1'b0},
            '{OP_TEXT,   8'h71,     BY_MODEL, 1'b0, 1'b0},
            '{OP_END,    8'h00,     BY_MODEL, 1'b0, 1'b0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_ROWS; k++) begin
            send_item(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].chk,
                      '{ovf: dir_rows[k].ovf, matched: dir_rows[k].matched});
        end

        // hold off until every verdict so far is back
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);

        run_session(1'b1);
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              BY_MODEL, '0);
                end
            end else begin
                run_session($urandom_range(0, 99) < 35);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d items sent, %0d verdicts checked", items_sent, verdicts_seen);
        $display("%0d verdicts matched, %0d flagged pattern overflow",
                 matches_seen, ovf_seen);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/wpm_pkg.sv
src/wpm_cell.sv
src/wpm_closure.sv
src/wpm_out_buf.sv
src/wildcard_pattern_matcher_core.sv
dv/wildcard_pattern_matcher_core_tb.sv
